// ===== rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and character helpers for the Polybius square codec.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_LZ    = 8'h7a;
  localparam logic [7:0] CHR_UA    = 8'h41;
  localparam logic [7:0] CHR_UZ    = 8'h5a;
  localparam logic [4:0] IDX_J     = 5'd9;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  // decrypt parser, one-hot
  typedef enum logic [3:0] {
    PH_LEAD = 4'b0001,
    PH_FREE = 4'b0010,
    PH_HELD = 4'b0100,
    PH_SKIP = 4'b1000
  } psc_phase_e;

  // results caused by one input item; cnt = 0 means none
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic            has_char;
    logic            last;
  } psc_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } psc_qstat_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= CHR_LA) && (b <= CHR_LZ)) || ((b >= CHR_UA) && (b <= CHR_UZ));
  endfunction

  // letter -> {row digit, column digit}; both cases share the low five bits
  function automatic logic [15:0] enc_digits(input logic [7:0] b);
    logic [4:0] idx;
    logic [2:0] row;
    logic [4:0] col;
    idx = b[4:0] - 5'd1;
    if (idx >= IDX_J) idx = idx - 5'd1;
    if (idx >= 5'd20)      row = 3'd4;
    else if (idx >= 5'd15) row = 3'd3;
    else if (idx >= 5'd10) row = 3'd2;
    else if (idx >= 5'd5)  row = 3'd1;
    else                   row = 3'd0;
    col = idx - 5'({2'b00, row} * 5'd5);
    return {CHR_ZERO + 8'(row) + 8'd1, CHR_ZERO + 8'(col) + 8'd1};
  endfunction

  // digit pair -> byte, 8-bit wraparound for pairs outside the square
  function automatic logic [7:0] pair_to_letter(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] idx;
    idx = 8'((hi - CHR_ZERO) * 8'd5) + (lo - CHR_ZERO) - 8'd6;
    if ($signed(idx) >= $signed({3'b000, IDX_J})) idx = idx + 8'd1;
    return CHR_LA + idx;
  endfunction

endpackage

// ===== rtl/psc_in_if.sv =====
// ----------------------------------------------------------------------------
// psc_in_if
// Input channel: one text byte per transfer with an end-of-text mark.
// ----------------------------------------------------------------------------
interface psc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/psc_out_if.sv =====
// ----------------------------------------------------------------------------
// psc_out_if
// Output channel: one result byte per transfer, empty-terminator flag, last mark.
// ----------------------------------------------------------------------------
interface psc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_char;
  logic       out_last;

  modport source (output valid, output out_byte, output has_char, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input has_char, input out_last,
                  output ready);
endinterface

// ===== rtl/polybius_square_stream_codec_unit.sv =====
// First result byte of an item: its bundle is written into the queue by the input transfer,
//   then loaded into the output register of the back part, from which it transfers.
// Throughput: one result byte per cycle while the output is ready and bundles are queued;
//   an item gives 1 to 3 result bytes, sent one at a time through the single output register.
// A new input is taken each cycle while the 2-entry bundle queue has room.
// Reset: stream state cleared, direction set to encrypt, queue and output emptied.
// ----------------------------------------------------------------------------
// polybius_square_stream_codec_unit
// Byte-stream 5x5 Polybius square encoder/decoder (J merged into I).
// ----------------------------------------------------------------------------
module polybius_square_stream_codec_unit
  import psc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  psc_in_if.sink     in_i,
  psc_out_if.source  out_o
);

  psc_bundle_t push_data, head;
  psc_qstat_t  qstat;
  logic        push, pop;

  psc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_s       (in_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .bundle_o   (push_data)
  );

  psc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(push_data),
    .pop_i  (pop),
    .rdata_o(head),
    .stat_o (qstat)
  );

  psc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .qstat_i(qstat),
    .pop_o  (pop),
    .out_s  (out_o)
  );

  // an empty terminator is always the final result and carries a zero byte
  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.has_char |-> out_o.out_last && (out_o.out_byte == 8'h00))
    else $error("empty terminator without last mark or with data");

  a_qstat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("bundle pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("bundle popped from an empty queue");

endmodule

// ===== rtl/psc_front.sv =====
// ----------------------------------------------------------------------------
// psc_front
// Accepts input bytes, runs the encrypt/decrypt classification and stream
// state, and posts the resulting byte bundle to the queue.
// ----------------------------------------------------------------------------
module psc_front
  import psc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  psc_in_if.sink        in_s,
  input  psc_qstat_t    qstat_i,
  output logic          push_o,
  output psc_bundle_t   bundle_o
);

  logic       dir_q;
  logic       sep_q, sep_d;
  psc_phase_e phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;

  assign in_s.ready = ~qstat_i.full;
  assign accept     = in_s.valid & in_s.ready;
  assign push_o     = accept & (bundle_o.cnt != 2'd0);

  always_comb begin
    logic [7:0]  b;
    logic        lst;
    logic [15:0] dg;
    logic        tok;
    b        = in_s.in_byte;
    lst      = in_s.in_last;
    dg       = enc_digits(b);
    tok      = 1'b0;
    sep_d    = sep_q;
    phase_d  = phase_q;
    held_d   = held_q;
    bundle_o = '0;
    bundle_o.has_char = 1'b1;
    bundle_o.last     = lst;

    if (dir_q == DIR_ENCRYPT) begin
      sep_d = 1'b1;
      if (is_letter(b)) begin
        if (sep_q) begin
          bundle_o.cnt  = 2'd3;
          bundle_o.data = {dg[7:0], dg[15:8], CHR_SPACE};
        end else begin
          bundle_o.cnt  = 2'd2;
          bundle_o.data = {8'h00, dg[7:0], dg[15:8]};
        end
      end else if (sep_q) begin
        bundle_o.cnt  = 2'd2;
        bundle_o.data = {8'h00, b, CHR_SPACE};
      end else begin
        bundle_o.cnt  = 2'd1;
        bundle_o.data = {16'h0000, b};
      end
    end else begin
      case (phase_q)
        PH_LEAD: begin
          if (b == CHR_SPACE) begin
            if (lst) begin
              bundle_o.cnt      = 2'd1;
              bundle_o.has_char = 1'b0;
            end
          end else begin
            tok = 1'b1;
          end
        end
        PH_FREE: tok = 1'b1;
        PH_HELD: begin
          if (b == CHR_SPACE) begin
            bundle_o.cnt  = 2'd1;
            bundle_o.data = {16'h0000, held_q};
            phase_d       = PH_FREE;
          end else if (is_digit(held_q) && is_digit(b)) begin
            bundle_o.cnt  = 2'd1;
            bundle_o.data = {16'h0000, pair_to_letter(held_q, b)};
            phase_d       = PH_SKIP;
          end else if (lst) begin
            bundle_o.cnt  = 2'd2;
            bundle_o.data = {8'h00, b, held_q};
          end else begin
            // held byte goes out alone, new byte is held
            bundle_o.cnt  = 2'd1;
            bundle_o.data = {16'h0000, held_q};
            held_d        = b;
          end
        end
        PH_SKIP: begin
          if (lst) begin
            bundle_o.cnt      = 2'd1;
            bundle_o.has_char = 1'b0;
          end
          phase_d = PH_FREE;
        end
        default: phase_d = PH_LEAD;
      endcase
      if (tok) begin
        if (lst) begin
          bundle_o.cnt  = 2'd1;
          bundle_o.data = {16'h0000, b};
        end else begin
          held_d  = b;
          phase_d = PH_HELD;
        end
      end
    end

    if (lst) begin
      sep_d   = 1'b0;
      phase_d = PH_LEAD;
      held_d  = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DIR_ENCRYPT;
      sep_q   <= 1'b0;
      phase_q <= PH_LEAD;
      held_q  <= 8'h00;
    end else if (cfg_we_i) begin
      dir_q   <= cfg_wdata_i;
      sep_q   <= 1'b0;
      phase_q <= PH_LEAD;
      held_q  <= 8'h00;
    end else if (accept) begin
      sep_q   <= sep_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== rtl/psc_queue.sv =====
// ----------------------------------------------------------------------------
// psc_queue
// Short FIFO of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module psc_queue
  import psc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  psc_bundle_t wdata_i,
  input  logic        pop_i,
  output psc_bundle_t rdata_o,
  output psc_qstat_t  stat_o
);

  psc_bundle_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/psc_back.sv =====
// ----------------------------------------------------------------------------
// psc_back
// Unpacks queued bundles into single result bytes through an output register.
// ----------------------------------------------------------------------------
module psc_back
  import psc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  psc_bundle_t head_i,
  input  psc_qstat_t  qstat_i,
  output logic        pop_o,
  psc_out_if.source   out_s
);

  logic       vld_q;
  logic [7:0] byte_q;
  logic       has_q, last_q;
  logic [1:0] idx_q;
  logic       load, final_one;

  assign load      = (~vld_q | out_s.ready) & ~qstat_i.empty;
  assign final_one = (idx_q == head_i.cnt - 2'd1);
  assign pop_o     = load & final_one;

  assign out_s.valid    = vld_q;
  assign out_s.out_byte = byte_q;
  assign out_s.has_char = has_q;
  assign out_s.out_last = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.data[idx_q];
      has_q  <= head_i.has_char;
      last_q <= head_i.last & final_one;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      if (load)               vld_q <= 1'b1;
      else if (out_s.ready)   vld_q <= 1'b0;
      if (pop_o)     idx_q <= 2'd0;
      else if (load) idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ===== dv/polybius_square_stream_codec_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polybius_square_stream_codec_unit_tb
// Self-checking bench for the Polybius square stream codec. Plain texts are
// encrypted and cipher texts decrypted, with random gaps on the input and random
// stalls on the output. A local codec model predicts every output byte.
// ----------------------------------------------------------------------------
module polybius_square_stream_codec_unit_tb;
  import psc_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } text_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  psc_in_if  in_ch ();
  psc_out_if out_ch ();

  polybius_square_stream_codec_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // codec model state
  logic       m_dir = DIR_ENCRYPT;
  logic       m_sep_pending = 1'b0;
  psc_phase_e m_phase = PH_LEAD;
  logic [7:0] m_held = 8'h00;

  text_char_t coded_text_q[$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         hold_left = 0;

  function automatic void put_char(input logic [7:0] c, input logic h, input logic l);
    text_char_t r;
    r.ch       = h ? c : 8'h00;
    r.has_char = h;
    r.last     = l;
    coded_text_q.push_back(r);
  endfunction

  function automatic void clear_stream();
    m_sep_pending = 1'b0;
    m_phase       = PH_LEAD;
    m_held        = 8'h00;
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

  function automatic logic [7:0] digits_to_char(input logic [7:0] hi, input logic [7:0] lo);
    int idx;
    idx = (int'(hi) - int'(CHR_ZERO) - 1) * 5 + int'(lo) - int'(CHR_ZERO) - 1;
    if (idx >= int'(IDX_J)) idx++;
    return 8'(int'(CHR_LA) + idx);
  endfunction

  function automatic void encode_char(input logic [7:0] b, input logic l);
    int idx;
    idx = -1;
    if (m_sep_pending) put_char(CHR_SPACE, 1'b1, 1'b0);
    if (b >= CHR_LA && b <= CHR_LZ) idx = int'(b) - int'(CHR_LA);
    else if (b >= CHR_UA && b <= CHR_UZ) idx = int'(b) - int'(CHR_UA);
    if (idx >= 0) begin
      if (idx >= int'(IDX_J)) idx--;
      put_char(8'(int'(CHR_ZERO) + idx / 5 + 1), 1'b1, 1'b0);
      put_char(8'(int'(CHR_ZERO) + idx % 5 + 1), 1'b1, l);
    end else begin
      put_char(b, 1'b1, l);
    end
    m_sep_pending = 1'b1;
  endfunction

  function automatic void decode_char(input logic [7:0] b, input logic l);
    if (m_phase == PH_LEAD && b == CHR_SPACE) begin
      if (l) put_char(8'h00, 1'b0, 1'b1);
    end else if (m_phase == PH_LEAD || m_phase == PH_FREE) begin
      if (l) begin
        put_char(b, 1'b1, 1'b1);
      end else begin
        m_held  = b;
        m_phase = PH_HELD;
      end
    end else if (m_phase == PH_HELD) begin
      if (b == CHR_SPACE) begin
        put_char(m_held, 1'b1, l);
        m_phase = PH_FREE;
      end else if (is_num(m_held) && is_num(b)) begin
        put_char(digits_to_char(m_held, b), 1'b1, l);
        m_phase = PH_SKIP;
      end else begin
        put_char(m_held, 1'b1, 1'b0);
        if (l) begin
          put_char(b, 1'b1, 1'b1);
        end else begin
          m_held = b;
        end
      end
    end else begin
      // byte right after a digit pair is dropped
      if (l) put_char(8'h00, 1'b0, 1'b1);
      m_phase = PH_FREE;
    end
  endfunction

  function automatic void codec_step(input logic [7:0] b, input logic l);
    if (m_dir == DIR_DECRYPT) decode_char(b, l);
    else encode_char(b, l);
    if (l) clear_stream();
  endfunction

  // output side: random stalls, plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (out_ch.valid && out_ch.ready) begin
      if (coded_text_q.size() == 0) begin
        $display("%0t: unexpected transfer: byte %h has_char %b last %b", $time,
                 out_ch.out_byte, out_ch.has_char, out_ch.out_last);
        mismatches++;
      end else begin
        exp_c = coded_text_q.pop_front();
        if (out_ch.out_byte !== exp_c.ch) begin
          $display("%0t: out_byte expected %h actual %h", $time, exp_c.ch, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.has_char !== exp_c.has_char) begin
          $display("%0t: has_char expected %b actual %b", $time, exp_c.has_char,
                   out_ch.has_char);
          mismatches++;
        end
        if (out_ch.out_last !== exp_c.last) begin
          $display("%0t: out_last expected %b actual %b", $time, exp_c.last, out_ch.out_last);
          mismatches++;
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    codec_step(b, l);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string(input string s, input bit terminate);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], terminate && (i == s.len() - 1));
  endtask

  // wait for all predicted bytes, then for anything still in the pipe
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (coded_text_q.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_direction(input logic d);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    m_dir = d;
    clear_stream();
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'(int'(CHR_LA) + $urandom_range(25));
    if ($urandom_range(1)) c = 8'(int'(CHR_UA) + $urandom_range(25));
    return c;
  endfunction

  task automatic send_plain_text(input bit terminate);
    int         len;
    logic [7:0] c;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      c = ($urandom_range(99) < 60) ? rand_letter() : 8'($urandom_range(255));
      send_byte(c, terminate && (i == len - 1));
    end
  endtask

  // mostly well-formed digit-pair texts, with lone bytes and noise mixed in
  task automatic send_cipher_text(input bit terminate);
    logic [7:0] chars[$];
    int         ntok;
    int         pick;
    ntok = $urandom_range(1, 6);
    repeat ($urandom_range(0, 2)) chars.push_back(CHR_SPACE);
    for (int t = 0; t < ntok; t++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        repeat (2) begin
          if ($urandom_range(99) < 85) chars.push_back(8'(int'(CHR_ZERO) + $urandom_range(1, 5)));
          else chars.push_back(8'(int'(CHR_ZERO) + $urandom_range(9)));
        end
      end else if (pick < 85) begin
        chars.push_back(rand_letter());
      end else begin
        repeat ($urandom_range(1, 2)) chars.push_back(8'($urandom_range(255)));
      end
      if (t != ntok - 1) begin
        pick = $urandom_range(99);
        if (pick < 85) chars.push_back(CHR_SPACE);
        else if (pick < 93) begin
          chars.push_back(CHR_SPACE);
          chars.push_back(CHR_SPACE);
        end
      end
    end
    for (int i = 0; i < chars.size(); i++)
      send_byte(chars[i], terminate && (i == chars.size() - 1));
  endtask

  task automatic test_encrypt_edges();
    set_direction(DIR_ENCRYPT);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_string("aZjJ@[{", 1'b1);
  endtask

  task automatic test_decrypt_edges();
    set_direction(DIR_DECRYPT);
    // leading space, out-of-square pairs, skipped bytes, lone byte before space
    send_string(" 99 06 x q", 1'b1);
    // lone space at end of text gives an empty terminator
    send_string(" ", 1'b1);
    // text ends on the byte after a pair
    send_string("45y", 1'b1);
    // held byte flushed together with the final one
    send_string("ab", 1'b1);
  endtask

  task automatic test_backpressure();
    set_direction(DIR_ENCRYPT);
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk_i);
    hold_left = 300;
    @(negedge clk_i);
    for (int i = 0; i < 40; i++) send_byte(rand_letter(), i == 39);
  endtask

  task automatic test_random_traffic(input int idle_p, input int stall_p, input int n_items);
    int target;
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    set_direction(DIR_ENCRYPT);
    target = items_sent + n_items / 2;
    while (items_sent < target) send_plain_text(1'b1);
    send_plain_text(1'b0);
    set_direction(DIR_DECRYPT);
    target = items_sent + n_items / 2;
    while (items_sent < target) send_cipher_text(1'b1);
    send_cipher_text(1'b0);
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = DIR_ENCRYPT;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_encrypt_edges();
    test_decrypt_edges();
    test_backpressure();
    test_random_traffic(0, 0, 72);
    test_random_traffic(57, 0, 72);
    test_random_traffic(0, 57, 72);
    test_random_traffic(11, 11, 72);

    drain_results();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psc_pkg.sv
rtl/psc_in_if.sv
rtl/psc_out_if.sv
rtl/psc_front.sv
rtl/psc_queue.sv
rtl/psc_back.sv
rtl/polybius_square_stream_codec_unit.sv
dv/polybius_square_stream_codec_unit_tb.sv
